FILE: rtl/wall_following_pid_speed_top_defines.svh
// Assertion macros shared by the wall-following PID speed controller
`ifndef WALL_FOLLOWING_PID_SPEED_TOP_DEFINES_SVH
`define WALL_FOLLOWING_PID_SPEED_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define WFPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define WFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wfps_pkg.sv
// Shared types and constants for the wall-following PID speed controller
package wfps_pkg;

    localparam int SENSOR_BITS_DEF = 12;
    localparam int SUM_BITS_DEF    = 24;
    localparam int GAIN_W          = 16;
    localparam int SPEED_W         = 16;
    localparam int FRAC_W          = 8;
    localparam int ACC_W           = SPEED_W + FRAC_W;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 3;

    localparam int THR_RESET       = 2048;
    localparam int GAIN_P_RESET    = 256;
    localparam int MAX_SPEED_RESET = 1000;
    localparam int FLOOR_RESET     = 170;

    typedef enum logic [1:0] {
        CASE_BOTH  = 2'd0,
        CASE_RIGHT = 2'd1,
        CASE_LEFT  = 2'd2,
        CASE_NONE  = 2'd3
    } wall_case_t;

    typedef enum logic {
        CMD_STEP      = 1'b0,
        CMD_CALIBRATE = 1'b1
    } command_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_THR  = 3'd0,
        REG_RIGHT_THR = 3'd1,
        REG_GAIN_P    = 3'd2,
        REG_GAIN_I    = 3'd3,
        REG_GAIN_D    = 3'd4,
        REG_LEFT_MAX  = 3'd5,
        REG_RIGHT_MAX = 3'd6,
        REG_FLOOR     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } gains_t;

    typedef struct packed {
        logic [SPEED_W-1:0] left_max;
        logic [SPEED_W-1:0] right_max;
        logic [SPEED_W-1:0] floor_speed;
    } speed_lim_t;

    typedef struct packed {
        command_t   cmd;
        wall_case_t wcase;
    } item_ctl_t;

endpackage

FILE: rtl/wfps_cfg.sv
// Configuration register file: thresholds, PID gains and speed limits
module wfps_cfg #(
    parameter int SENSOR_BITS = wfps_pkg::SENSOR_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wfps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wfps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [SENSOR_BITS-1:0]           left_thr,
    output logic [SENSOR_BITS-1:0]           right_thr,
    output wfps_pkg::gains_t                 gains,
    output wfps_pkg::speed_lim_t             lim
);
    import wfps_pkg::*;

    logic [SENSOR_BITS-1:0]   left_thr_reg;
    logic [SENSOR_BITS-1:0]   right_thr_reg;
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic signed [GAIN_W-1:0] kd_reg;
    logic [SPEED_W-1:0]       left_max_reg;
    logic [SPEED_W-1:0]       right_max_reg;
    logic [SPEED_W-1:0]       floor_reg;

    // Decode the index and load the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_thr_reg  <= SENSOR_BITS'(THR_RESET);
            right_thr_reg <= SENSOR_BITS'(THR_RESET);
            kp_reg        <= GAIN_W'(GAIN_P_RESET);
            ki_reg        <= '0;
            kd_reg        <= '0;
            left_max_reg  <= SPEED_W'(MAX_SPEED_RESET);
            right_max_reg <= SPEED_W'(MAX_SPEED_RESET);
            floor_reg     <= SPEED_W'(FLOOR_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_THR:  left_thr_reg  <= cfg_data[SENSOR_BITS-1:0];
                REG_RIGHT_THR: right_thr_reg <= cfg_data[SENSOR_BITS-1:0];
                REG_GAIN_P:    kp_reg        <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_I:    ki_reg        <= $signed(cfg_data[GAIN_W-1:0]);
                REG_GAIN_D:    kd_reg        <= $signed(cfg_data[GAIN_W-1:0]);
                REG_LEFT_MAX:  left_max_reg  <= cfg_data[SPEED_W-1:0];
                REG_RIGHT_MAX: right_max_reg <= cfg_data[SPEED_W-1:0];
                REG_FLOOR:     floor_reg     <= cfg_data[SPEED_W-1:0];
                default:       ;
            endcase
        end
    end

    assign left_thr        = left_thr_reg;
    assign right_thr       = right_thr_reg;
    assign gains.kp        = kp_reg;
    assign gains.ki        = ki_reg;
    assign gains.kd        = kd_reg;
    assign lim.left_max    = left_max_reg;
    assign lim.right_max   = right_max_reg;
    assign lim.floor_speed = floor_reg;

endmodule

FILE: rtl/wfps_err.sv
// Wall classification, error forming and error-sum state (first work stage)
module wfps_err #(
    parameter int SENSOR_BITS = wfps_pkg::SENSOR_BITS_DEF,
    parameter int SUM_BITS    = wfps_pkg::SUM_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  wfps_pkg::command_t                cmd,
    input  logic [SENSOR_BITS-1:0]            left_ir,
    input  logic [SENSOR_BITS-1:0]            right_ir,
    input  logic [SENSOR_BITS-1:0]            left_thr,
    input  logic [SENSOR_BITS-1:0]            right_thr,
    output logic signed [SENSOR_BITS+1:0]     err,
    output logic signed [SENSOR_BITS+2:0]     diff,
    output logic signed [SUM_BITS-1:0]        sum_old,
    output wfps_pkg::item_ctl_t               ctl
);
    import wfps_pkg::*;

    localparam int ERR_W = SENSOR_BITS + 2;
    localparam int DIF_W = ERR_W + 1;
    localparam int NS_W  = ((SUM_BITS > ERR_W) ? SUM_BITS : ERR_W) + 1;
    localparam logic signed [NS_W-1:0] SUM_MAX = NS_W'((longint'(1) <<< (SUM_BITS - 1)) - 1);
    localparam logic signed [NS_W-1:0] SUM_MIN = -SUM_MAX - NS_W'(1);

    // Error state; the past error always equals the present one after a step
    logic signed [ERR_W-1:0]       present_err_reg;
    logic signed [SUM_BITS-1:0]    error_sum_reg;
    wall_case_t                    prev_case_reg;
    logic signed [SENSOR_BITS:0]   wall_offset_reg;
    logic [SENSOR_BITS-1:0]        left_target_reg;
    logic [SENSOR_BITS-1:0]        right_target_reg;

    // Stage outputs
    logic signed [ERR_W-1:0]       err_reg;
    logic signed [DIF_W-1:0]       diff_reg;
    logic signed [SUM_BITS-1:0]    sum_old_reg;
    item_ctl_t                     ctl_reg;

    logic                          left_wall;
    logic                          right_wall;
    wall_case_t                    case_next;
    logic signed [ERR_W-1:0]       l_s;
    logic signed [ERR_W-1:0]       r_s;
    logic signed [ERR_W-1:0]       lt_s;
    logic signed [ERR_W-1:0]       rt_s;
    logic signed [ERR_W-1:0]       off_s;
    logic signed [ERR_W-1:0]       err_next;
    logic signed [NS_W-1:0]        sum_raw;
    logic signed [SUM_BITS-1:0]    sum_next;
    logic signed [SENSOR_BITS:0]   offset_next;

    assign l_s   = $signed({2'b00, left_ir});
    assign r_s   = $signed({2'b00, right_ir});
    assign lt_s  = $signed({2'b00, left_target_reg});
    assign rt_s  = $signed({2'b00, right_target_reg});
    assign off_s = {wall_offset_reg[SENSOR_BITS], wall_offset_reg};

    assign offset_next = $signed({1'b0, left_ir}) - $signed({1'b0, right_ir});

    // Sort the walls into one of four cases
    always_comb
    begin
        left_wall  = (left_ir >= left_thr);
        right_wall = (right_ir >= right_thr);
        if (left_wall && right_wall)
            case_next = CASE_BOTH;
        else if (right_wall)
            case_next = CASE_RIGHT;
        else if (left_wall)
            case_next = CASE_LEFT;
        else
            case_next = CASE_NONE;
    end

    // Form the error; the both-wall error refreshes only when the last step, or reset, left the both-wall case
    always_comb
    begin
        case (case_next)
            CASE_BOTH:
                err_next = (prev_case_reg == CASE_BOTH) ? (l_s - r_s - off_s)
                                                        : present_err_reg;
            CASE_RIGHT: err_next = rt_s - r_s;
            CASE_LEFT:  err_next = l_s - lt_s;
            default:    err_next = '0;
        endcase
    end

    // Saturate the running error sum
    always_comb
    begin
        sum_raw = NS_W'(error_sum_reg) + NS_W'(err_next);
        if (sum_raw > SUM_MAX)
            sum_next = SUM_BITS'(SUM_MAX);
        else if (sum_raw < SUM_MIN)
            sum_next = SUM_BITS'(SUM_MIN);
        else
            sum_next = SUM_BITS'(sum_raw);
    end

    // Update calibration and error state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_err_reg  <= '0;
            error_sum_reg    <= '0;
            prev_case_reg    <= CASE_BOTH;
            wall_offset_reg  <= '0;
            left_target_reg  <= '0;
            right_target_reg <= '0;
        end
        else if (en)
        begin
            if (cmd == CMD_CALIBRATE)
            begin
                wall_offset_reg  <= offset_next;
                left_target_reg  <= left_ir;
                right_target_reg <= right_ir;
            end
            else
            begin
                present_err_reg <= err_next;
                error_sum_reg   <= sum_next;
                prev_case_reg   <= case_next;
            end
        end
    end

    // Hand the error terms to the multiply stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg       <= err_next;
            diff_reg      <= DIF_W'(err_next) - DIF_W'(present_err_reg);
            sum_old_reg   <= error_sum_reg;
            ctl_reg.cmd   <= cmd;
            ctl_reg.wcase <= (cmd == CMD_CALIBRATE) ? prev_case_reg : case_next;
        end
    end

    assign err     = err_reg;
    assign diff    = diff_reg;
    assign sum_old = sum_old_reg;
    assign ctl     = ctl_reg;

endmodule

FILE: rtl/wfps_gain.sv
// PID gain multipliers: three signed products, registered
module wfps_gain #(
    parameter int SENSOR_BITS = wfps_pkg::SENSOR_BITS_DEF,
    parameter int SUM_BITS    = wfps_pkg::SUM_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        en,
    input  logic signed [SENSOR_BITS+1:0]               err,
    input  logic signed [SENSOR_BITS+2:0]               diff,
    input  logic signed [SUM_BITS-1:0]                  sum_old,
    input  wfps_pkg::item_ctl_t                         ctl_in,
    input  wfps_pkg::gains_t                            gains,
    output logic signed [wfps_pkg::GAIN_W+SENSOR_BITS+1:0] prod_p,
    output logic signed [wfps_pkg::GAIN_W+SENSOR_BITS+2:0] prod_d,
    output logic signed [wfps_pkg::GAIN_W+SUM_BITS-1:0]    prod_i,
    output wfps_pkg::item_ctl_t                         ctl
);
    import wfps_pkg::*;

    localparam int PP_W = GAIN_W + SENSOR_BITS + 2;
    localparam int PD_W = GAIN_W + SENSOR_BITS + 3;
    localparam int PI_W = GAIN_W + SUM_BITS;

    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [PP_W-1:0]   prod_p_reg;
    logic signed [PD_W-1:0]   prod_d_reg;
    logic signed [PI_W-1:0]   prod_i_reg;
    item_ctl_t                ctl_reg;

    assign kp = gains.kp;
    assign ki = gains.ki;
    assign kd = gains.kd;

    // Multiply each error term by its gain
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_p_reg <= PP_W'(kp) * PP_W'(err);
            prod_d_reg <= PD_W'(kd) * PD_W'(diff);
            prod_i_reg <= PI_W'(ki) * PI_W'(sum_old);
            ctl_reg    <= ctl_in;
        end
    end

    assign prod_p = prod_p_reg;
    assign prod_d = prod_d_reg;
    assign prod_i = prod_i_reg;
    assign ctl    = ctl_reg;

endmodule

FILE: rtl/wfps_speed.sv
// Speed accumulators: add the PID total, clamp, and hold the result beat
module wfps_speed #(
    parameter int SENSOR_BITS = wfps_pkg::SENSOR_BITS_DEF,
    parameter int SUM_BITS    = wfps_pkg::SUM_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic signed [wfps_pkg::GAIN_W+SENSOR_BITS+1:0] prod_p,
    input  logic signed [wfps_pkg::GAIN_W+SENSOR_BITS+2:0] prod_d,
    input  logic signed [wfps_pkg::GAIN_W+SUM_BITS-1:0]    prod_i,
    input  wfps_pkg::item_ctl_t                         ctl,
    input  wfps_pkg::speed_lim_t                        lim,
    output logic [wfps_pkg::SPEED_W-1:0]                left_speed,
    output logic [wfps_pkg::SPEED_W-1:0]                right_speed,
    output logic [1:0]                                  wall_case
);
    import wfps_pkg::*;

    localparam int PP_W  = GAIN_W + SENSOR_BITS + 2;
    localparam int PD_W  = GAIN_W + SENSOR_BITS + 3;
    localparam int PI_W  = GAIN_W + SUM_BITS;
    localparam int MX_W  = (PD_W > PI_W) ? PD_W : PI_W;
    localparam int TOT_W = MX_W + 2;
    localparam int V_W   = ((TOT_W > ACC_W) ? TOT_W : ACC_W) + 2;

    logic [ACC_W-1:0]         left_acc_reg;
    logic [ACC_W-1:0]         right_acc_reg;
    wall_case_t               wall_case_reg;
    logic signed [TOT_W-1:0]  total;
    logic signed [V_W-1:0]    left_sum;
    logic signed [V_W-1:0]    right_sum;
    logic [ACC_W-1:0]         left_acc_next;
    logic [ACC_W-1:0]         right_acc_next;

    // Cap at the maximum, then replace a negative speed by the floor speed
    function automatic logic [ACC_W-1:0] clamp_speed(
        input logic signed [V_W-1:0] v,
        input logic [SPEED_W-1:0]    max_speed,
        input logic [SPEED_W-1:0]    floor_speed
    );
        logic signed [V_W-1:0] top;
        logic [ACC_W-1:0]      res;
        top = $signed({{(V_W-ACC_W){1'b0}}, max_speed, {FRAC_W{1'b0}}});
        if (v > top)
            res = top[ACC_W-1:0];
        else if (v < 0)
            res = {floor_speed, {FRAC_W{1'b0}}};
        else
            res = v[ACC_W-1:0];
        return res;
    endfunction

    // Sum the PID terms and apply them with opposite signs to the two wheels
    always_comb
    begin
        total     = TOT_W'(prod_p) + TOT_W'(prod_d) + TOT_W'(prod_i);
        left_sum  = $signed({{(V_W-ACC_W){1'b0}}, left_acc_reg}) + V_W'(total);
        right_sum = $signed({{(V_W-ACC_W){1'b0}}, right_acc_reg}) - V_W'(total);
        left_acc_next  = clamp_speed(left_sum, lim.left_max, lim.floor_speed);
        right_acc_next = clamp_speed(right_sum, lim.right_max, lim.floor_speed);
    end

    // Advance the accumulators on a step; hold them on a calibrate beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
            wall_case_reg <= CASE_BOTH;
        end
        else if (en)
        begin
            if (ctl.cmd == CMD_STEP)
            begin
                left_acc_reg  <= left_acc_next;
                right_acc_reg <= right_acc_next;
            end
            wall_case_reg <= ctl.wcase;
        end
    end

    assign left_speed  = left_acc_reg[ACC_W-1:FRAC_W];
    assign right_speed = right_acc_reg[ACC_W-1:FRAC_W];
    assign wall_case   = wall_case_reg;

endmodule

FILE: rtl/wall_following_pid_speed_top.sv
// Top level of the wall-following PID speed controller
// Each beat carries a command and a left and right IR sample and yields one
// result beat: both wheel speeds and the wall case. An accepted input passes
// in order through the input register, error stage, multiply stage and the
// accumulator and output register, and one beat is taken every cycle as long
// as results drain. The rate is set by the speed accumulator loop, which adds
// the three gain products and clamps them combinationally. in_ready follows
// out_ready combinationally when all four stages are full.
`include "wall_following_pid_speed_top_defines.svh"

module wall_following_pid_speed_top #(
    parameter int SENSOR_BITS = wfps_pkg::SENSOR_BITS_DEF,
    parameter int SUM_BITS    = wfps_pkg::SUM_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wfps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wfps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic [SENSOR_BITS-1:0]           left_ir,
    input  logic [SENSOR_BITS-1:0]           right_ir,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [wfps_pkg::SPEED_W-1:0]     left_speed,
    output logic [wfps_pkg::SPEED_W-1:0]     right_speed,
    output logic [1:0]                       wall_case
);
    import wfps_pkg::*;

    localparam int ERR_W = SENSOR_BITS + 2;
    localparam int DIF_W = ERR_W + 1;
    localparam int PP_W  = GAIN_W + SENSOR_BITS + 2;
    localparam int PD_W  = GAIN_W + SENSOR_BITS + 3;
    localparam int PI_W  = GAIN_W + SUM_BITS;

    // Stage valids
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;

    // Input register
    command_t                cmd_reg;
    logic [SENSOR_BITS-1:0]  left_ir_reg;
    logic [SENSOR_BITS-1:0]  right_ir_reg;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s0_free;
    logic adv1;
    logic adv2;
    logic adv3;

    logic [SENSOR_BITS-1:0]    left_thr;
    logic [SENSOR_BITS-1:0]    right_thr;
    gains_t                    gains;
    speed_lim_t                lim;
    logic signed [ERR_W-1:0]   err;
    logic signed [DIF_W-1:0]   diff;
    logic signed [SUM_BITS-1:0] sum_old;
    item_ctl_t                 s1_ctl;
    logic signed [PP_W-1:0]    prod_p;
    logic signed [PD_W-1:0]    prod_d;
    logic signed [PI_W-1:0]    prod_i;
    item_ctl_t                 s2_ctl;

    // Move each stage forward when the one after it has room
    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign adv1     = s0_valid_reg && s1_free;
    assign adv2     = s1_valid_reg && s2_free;
    assign adv3     = s2_valid_reg && out_free;
    assign in_ready = s0_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_free)
                s0_valid_reg <= in_valid;
            if (s1_free)
                s1_valid_reg <= s0_valid_reg;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_valid && s0_free)
        begin
            cmd_reg      <= command_t'(command);
            left_ir_reg  <= left_ir;
            right_ir_reg <= right_ir;
        end
    end

    wfps_cfg #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .left_thr  (left_thr),
        .right_thr (right_thr),
        .gains     (gains),
        .lim       (lim)
    );

    wfps_err #(
        .SENSOR_BITS (SENSOR_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv1),
        .cmd       (cmd_reg),
        .left_ir   (left_ir_reg),
        .right_ir  (right_ir_reg),
        .left_thr  (left_thr),
        .right_thr (right_thr),
        .err       (err),
        .diff      (diff),
        .sum_old   (sum_old),
        .ctl       (s1_ctl)
    );

    wfps_gain #(
        .SENSOR_BITS (SENSOR_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_gain (
        .clk     (clk),
        .en      (adv2),
        .err     (err),
        .diff    (diff),
        .sum_old (sum_old),
        .ctl_in  (s1_ctl),
        .gains   (gains),
        .prod_p  (prod_p),
        .prod_d  (prod_d),
        .prod_i  (prod_i),
        .ctl     (s2_ctl)
    );

    wfps_speed #(
        .SENSOR_BITS (SENSOR_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_speed (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv3),
        .prod_p      (prod_p),
        .prod_d      (prod_d),
        .prod_i      (prod_i),
        .ctl         (s2_ctl),
        .lim         (lim),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .wall_case   (wall_case)
    );

    assign out_valid = out_valid_reg;

    // Back-pressure only when every stage holds a beat
    `WFPS_ASSERT_IMPL(a_ready_full, !in_ready,
        s0_valid_reg && s1_valid_reg && s2_valid_reg && out_valid_reg,
        "in_ready low with a free stage")

    // A step result stays within its limit or sits at the floor speed
    `WFPS_ASSERT_NEXT(a_step_clamp, adv3 && (s2_ctl.cmd == CMD_STEP),
        (left_speed <= lim.left_max || left_speed == lim.floor_speed)
        && (right_speed <= lim.right_max || right_speed == lim.floor_speed),
        "speed outside clamp range")

    // A calibrate beat leaves the speeds and wall case untouched
    `WFPS_ASSERT_NEXT(a_cal_hold, adv3 && (s2_ctl.cmd == CMD_CALIBRATE),
        $stable(left_speed) && $stable(right_speed) && $stable(wall_case),
        "calibrate changed the held result")

endmodule

FILE: sim/wall_following_pid_speed_top_tb.sv
// Self-checking testbench for the wall-following PID speed controller
module wall_following_pid_speed_top_tb;

    import wfps_pkg::*;

    localparam int SB            = SENSOR_BITS_DEF;
    localparam int SENSOR_MAX    = (1 << SB) - 1;
    localparam int HOLD_CYCLES   = 250;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;
    localparam longint SUM_TOP   = (longint'(1) << (SUM_BITS_DEF - 1)) - 1;
    localparam longint SUM_BOT   = -SUM_TOP - 1;

    typedef struct {
        command_t        cmd;
        logic [SB-1:0]   left;
        logic [SB-1:0]   right;
    } sensor_beat_t;

    typedef struct {
        logic [SPEED_W-1:0] left;
        logic [SPEED_W-1:0] right;
        wall_case_t         wcase;
    } speeds_t;

    // DUT connections; the driven inputs are all known from time zero
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  command = 1'b0;
    logic [SB-1:0]         left_ir = '0;
    logic [SB-1:0]         right_ir = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SPEED_W-1:0]    left_speed;
    logic [SPEED_W-1:0]    right_speed;
    logic [1:0]            wall_case;

    // Controller configuration as the predictor sees it
    logic [SB-1:0]            left_thr   = SB'(THR_RESET);
    logic [SB-1:0]            right_thr  = SB'(THR_RESET);
    logic signed [GAIN_W-1:0] kp         = GAIN_W'(GAIN_P_RESET);
    logic signed [GAIN_W-1:0] ki         = '0;
    logic signed [GAIN_W-1:0] kd         = '0;
    logic [SPEED_W-1:0]       left_max   = SPEED_W'(MAX_SPEED_RESET);
    logic [SPEED_W-1:0]       right_max  = SPEED_W'(MAX_SPEED_RESET);
    logic [SPEED_W-1:0]       floor_spd  = SPEED_W'(FLOOR_RESET);

    // Controller state as the predictor sees it
    logic signed [13:0]             past_err  = '0;
    logic signed [13:0]             pres_err  = '0;
    logic signed [SUM_BITS_DEF-1:0] err_sum   = '0;
    wall_case_t                     prev_case = CASE_BOTH;
    logic [ACC_W-1:0]               left_acc  = '0;
    logic [ACC_W-1:0]               right_acc = '0;
    logic signed [SB:0]             wall_off  = '0;
    logic [SB-1:0]                  left_tgt  = '0;
    logic [SB-1:0]                  right_tgt = '0;

    sensor_beat_t sensor_beats[$];
    speeds_t      speeds_due[$];

    bit idle_on      = 1'b1;
    int send_gap     = 0;
    int ready_gap    = 0;
    int hold_left    = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int mismatches   = 0;
    int stall_cycles = 0;

    wall_following_pid_speed_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .left_ir     (left_ir),
        .right_ir    (right_ir),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .wall_case   (wall_case)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Clamp a speed to its maximum, then replace a negative one by the floor speed
    function automatic longint clamp_speed(longint v, logic [SPEED_W-1:0] top_int);
        longint top;
        top = longint'(top_int) * 256;
        if (v > top)
            v = top;
        if (v < 0)
            v = longint'(floor_spd) * 256;
        return v;
    endfunction

    // Advance the predicted controller by one accepted beat and queue its speeds
    task automatic step_controller(command_t cmd, logic [SB-1:0] l, logic [SB-1:0] r);
        bit      lw;
        bit      rw;
        longint  e;
        longint  total;
        longint  ns;
        speeds_t want;
        if (cmd == CMD_CALIBRATE) begin
            wall_off  = (SB+1)'(longint'(l) - longint'(r));
            left_tgt  = l;
            right_tgt = r;
        end else begin
            lw = (l >= left_thr);
            rw = (r >= right_thr);
            if (lw && rw) begin
                // both-wall error only moves when the last step, or the start, saw both walls
                if (prev_case == CASE_BOTH)
                    pres_err = 14'(longint'(l) - longint'(r) - longint'(wall_off));
                prev_case = CASE_BOTH;
            end else if (rw) begin
                pres_err  = 14'(longint'(right_tgt) - longint'(r));
                prev_case = CASE_RIGHT;
            end else if (lw) begin
                pres_err  = 14'(longint'(l) - longint'(left_tgt));
                prev_case = CASE_LEFT;
            end else begin
                pres_err  = '0;
                prev_case = CASE_NONE;
            end
            e = longint'(pres_err);
            total = longint'(kp) * e + longint'(kd) * (e - longint'(past_err))
                  + longint'(ki) * longint'(err_sum);
            left_acc  = ACC_W'(clamp_speed(longint'(left_acc) + total, left_max));
            right_acc = ACC_W'(clamp_speed(longint'(right_acc) - total, right_max));
            past_err  = pres_err;
            // saturate the running error sum
            ns = longint'(err_sum) + e;
            if (ns > SUM_TOP)
                ns = SUM_TOP;
            if (ns < SUM_BOT)
                ns = SUM_BOT;
            err_sum = SUM_BITS_DEF'(ns);
        end
        want.left  = left_acc[ACC_W-1:FRAC_W];
        want.right = right_acc[ACC_W-1:FRAC_W];
        want.wcase = prev_case;
        speeds_due.push_back(want);
    endtask

    // Drive one register write and mirror it into the predictor
    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_LEFT_THR:  left_thr  = val[SB-1:0];
            REG_RIGHT_THR: right_thr = val[SB-1:0];
            REG_GAIN_P:    kp        = val;
            REG_GAIN_I:    ki        = val;
            REG_GAIN_D:    kd        = val;
            REG_LEFT_MAX:  left_max  = val;
            REG_RIGHT_MAX: right_max = val;
            REG_FLOOR:     floor_spd = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly modest gains so speeds move without pinning at the clamps
    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        if ($urandom_range(0, 4) == 0)
            return CFG_DATA_W'($urandom());
        return CFG_DATA_W'($urandom_range(0, 1023)) - CFG_DATA_W'(512);
    endfunction

    task automatic random_config();
        write_reg(REG_LEFT_THR,  CFG_DATA_W'($urandom_range(0, SENSOR_MAX)));
        write_reg(REG_RIGHT_THR, CFG_DATA_W'($urandom_range(0, SENSOR_MAX)));
        write_reg(REG_GAIN_P,    pick_gain());
        write_reg(REG_GAIN_I,    pick_gain());
        write_reg(REG_GAIN_D,    pick_gain());
        write_reg(REG_LEFT_MAX,  CFG_DATA_W'($urandom_range(0, 4000)));
        write_reg(REG_RIGHT_MAX, CFG_DATA_W'($urandom()));
        write_reg(REG_FLOOR,     CFG_DATA_W'($urandom_range(0, 2000)));
        end_writes();
    endtask

    task automatic push_beat(command_t cmd, int l, int r);
        sensor_beat_t b;
        b.cmd   = cmd;
        b.left  = SB'(l);
        b.right = SB'(r);
        sensor_beats.push_back(b);
    endtask

    // Sample biased toward the extremes and the wall threshold
    function automatic int pick_sample(logic [SB-1:0] thr);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 1) ? SENSOR_MAX : 0;
            1: v = int'(thr) + $urandom_range(0, 8) - 4;
            default: v = $urandom_range(0, SENSOR_MAX);
        endcase
        if (v < 0)
            v = 0;
        if (v > SENSOR_MAX)
            v = SENSOR_MAX;
        return v;
    endfunction

    task automatic push_random(int n);
        repeat (n)
            push_beat(($urandom_range(0, 9) == 0) ? CMD_CALIBRATE : CMD_STEP,
                      pick_sample(left_thr), pick_sample(right_thr));
    endtask

    // Wait until every beat is sent and every result is back, then let the pipe settle
    task automatic drain();
        do
            @(posedge clk);
        while (sensor_beats.size() != 0 || in_valid || speeds_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: hold a beat until taken, idle in random bursts
    always @(posedge clk)
    begin : feed_sensors
        sensor_beat_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                step_controller(command_t'(command), left_ir, right_ir);
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (idle_on && sensor_beats.size() != 0
                             && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    in_valid <= 1'b0;
                end else if (sensor_beats.size() != 0) begin
                    nxt = sensor_beats.pop_front();
                    command  <= nxt.cmd;
                    left_ir  <= nxt.left;
                    right_ir <= nxt.right;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts plus a long hold-off on request
    always @(posedge clk)
    begin : take_speeds
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            ready_gap = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_speeds
        speeds_t want;
        if (rst_n && out_valid && out_ready) begin
            if (speeds_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result beat with nothing expected: left %0d right %0d case %0d",
                             $time, left_speed, right_speed, wall_case);
            end else begin
                want = speeds_due.pop_front();
                if (left_speed !== want.left || right_speed !== want.right
                    || wall_case !== want.wcase) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"%0t: mismatch: left exp %0d got %0d, right exp %0d got %0d,",
                                  " case exp %0d got %0d"}, $time, want.left, left_speed,
                                 want.right, right_speed, want.wcase, wall_case);
                end
            end
        end
    end

    // Watchdog: give up when nothing moves while work is pending
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (sensor_beats.size() == 0 && !in_valid && speeds_due.size() == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : run
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats on reset settings: walls, targets, clamps, floor
        push_beat(CMD_STEP, 2048, 2048);
        push_beat(CMD_STEP, 0, 0);
        push_beat(CMD_STEP, SENSOR_MAX, 0);
        push_beat(CMD_STEP, 0, SENSOR_MAX);
        push_beat(CMD_STEP, SENSOR_MAX, 2048);
        push_beat(CMD_STEP, SENSOR_MAX, 2048);
        push_beat(CMD_CALIBRATE, 3000, 2500);
        push_beat(CMD_STEP, 3000, 2500);
        push_beat(CMD_CALIBRATE, SENSOR_MAX, 0);
        push_beat(CMD_STEP, 0, SENSOR_MAX);
        push_beat(CMD_STEP, 2048, SENSOR_MAX);
        push_beat(CMD_STEP, 2048, SENSOR_MAX);
        push_beat(CMD_CALIBRATE, 0, SENSOR_MAX);
        push_beat(CMD_STEP, SENSOR_MAX, 2048);
        push_beat(CMD_STEP, SENSOR_MAX, SENSOR_MAX);
        push_beat(CMD_STEP, 2047, 2047);
        push_beat(CMD_STEP, 2048, 2047);
        push_beat(CMD_STEP, 2047, 2048);
        push_beat(CMD_CALIBRATE, 0, 0);
        push_beat(CMD_STEP, 1, 4094);
        push_beat(CMD_CALIBRATE, SENSOR_MAX, SENSOR_MAX);
        push_beat(CMD_STEP, 2730, 1365);
        drain();

        // Random settings, with one long receiver hold-off
        random_config();
        push_random(100);
        holds_asked++;
        drain();

        // Extreme settings, one way
        write_reg(REG_LEFT_THR,  '0);
        write_reg(REG_RIGHT_THR, CFG_DATA_W'(SENSOR_MAX));
        write_reg(REG_GAIN_P,    16'h8000);
        write_reg(REG_GAIN_I,    16'h7fff);
        write_reg(REG_GAIN_D,    16'h8000);
        write_reg(REG_LEFT_MAX,  16'hffff);
        write_reg(REG_RIGHT_MAX, '0);
        write_reg(REG_FLOOR,     16'hffff);
        end_writes();
        push_random(60);
        drain();

        // Extreme settings, the other way
        write_reg(REG_LEFT_THR,  CFG_DATA_W'(SENSOR_MAX));
        write_reg(REG_RIGHT_THR, '0);
        write_reg(REG_GAIN_P,    16'h7fff);
        write_reg(REG_GAIN_I,    16'h8000);
        write_reg(REG_GAIN_D,    16'h7fff);
        write_reg(REG_LEFT_MAX,  '0);
        write_reg(REG_RIGHT_MAX, 16'hffff);
        write_reg(REG_FLOOR,     '0);
        end_writes();
        push_random(60);
        drain();

        // Drive the error sum into saturation: both walls always, large steady error
        random_config();
        write_reg(REG_LEFT_THR,  '0);
        write_reg(REG_RIGHT_THR, '0);
        write_reg(REG_LEFT_MAX,  16'hffff);
        end_writes();
        push_beat(CMD_CALIBRATE, 0, SENSOR_MAX);
        repeat (1150) begin
            if ($urandom_range(0, 11) == 0)
                push_beat(CMD_STEP, $urandom_range(0, SENSOR_MAX),
                          $urandom_range(0, SENSOR_MAX));
            else
                push_beat(CMD_STEP, SENSOR_MAX - $urandom_range(0, 31),
                          $urandom_range(0, 31));
        end
        holds_asked++;
        drain();

        // Closing stretch at full rate
        random_config();
        idle_on = 1'b0;
        push_random(80);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && speeds_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
